>>> rtl/core/bpa_pkg.sv
// Shared constants, types and codes for the bitmap page allocator.
package bpa_pkg;

    localparam int MAX_PAGES  = 4096;
    localparam int PAGE_BYTES = 4096;
    localparam int PAGE_SHIFT = $clog2(PAGE_BYTES);

    // Bitmap is held as words; MAX_PAGES is a multiple of WORD_BITS.
    localparam int WORD_BITS = 32;
    localparam int BIT_W     = $clog2(WORD_BITS);
    localparam int NUM_WORDS = MAX_PAGES / WORD_BITS;
    localparam int ROW_W     = $clog2(NUM_WORDS);
    localparam int PAGE_W    = $clog2(MAX_PAGES);

    // Field widths fixed by the interface.
    localparam int CNT_W     = 13;
    localparam int POOL_W    = 13;
    localparam int ADDR_W    = 32;
    localparam int START_W   = 12;
    localparam int CFG_IDX_W = 1;
    localparam int POOL_RESET = 4096;

    // Page counts and limits, and the running free-run length.
    localparam int SPAN_W = (PAGE_W + 1 > CNT_W) ? PAGE_W + 1 : CNT_W;
    localparam int RUN_W  = SPAN_W + 1;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_BASE_ADDRESS = CFG_IDX_W'(0),
        REG_POOL_PAGES   = CFG_IDX_W'(1)
    } cfg_reg_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_MARK_RD,
        ST_MARK_FIRST,
        ST_MARK_MID,
        ST_RESULT
    } seq_state_t;

    // One bitmap word to examine, with the scan context.
    typedef struct packed {
        logic [WORD_BITS-1:0] used;
        logic [SPAN_W-1:0]    rem;    // pages of the pool from this word's base
        logic [RUN_W-1:0]     carry;  // free run ending just below this word
        logic [SPAN_W-1:0]    cnt;
    } scan_req_t;

    typedef struct packed {
        logic             hit;
        logic [BIT_W-1:0] pos;        // bit where the first fitting run ends
        logic [RUN_W-1:0] carry_next;
    } scan_rsp_t;

    typedef struct packed {
        logic              granted;
        logic [PAGE_W-1:0] start;
    } alloc_res_t;

endpackage

>>> rtl/core/bitmap_page_allocator_core.sv
// Top level of the bitmap first-fit page allocator.
//
//  channel   dir  signals                                        beat
//  request   in   in_valid/in_ready, page_count                   one request
//  result    out  out_valid/out_ready, granted, start_page,       one answer
//                 start_address
//  config    in   cfg_valid/cfg_ready, cfg_index, cfg_data        one register write
//
//  Rejected request (zero count or count above the pool): goes straight to the result.
//  Otherwise the scan reads 32-page words up to the one where the run ends (every pool
//  word, at most 128, on a miss), one bitmap word read per cycle; a miss then gives the
//  result, a grant first reads the run's first word and writes every word it spans.
//  Row valid bits cleared at reset replace a clearing pass; cfg_ready is always high.
//  Answers wait in the output register while the next request runs; stall only if full.
module bitmap_page_allocator_core (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [bpa_pkg::CNT_W-1:0]         page_count,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic                              granted,
    output logic [bpa_pkg::START_W-1:0]       start_page,
    output logic [bpa_pkg::ADDR_W-1:0]        start_address,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [bpa_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [bpa_pkg::ADDR_W-1:0]        cfg_data
);

    // configuration registers
    logic [bpa_pkg::ADDR_W-1:0]  base_address_reg;
    logic [bpa_pkg::POOL_W-1:0]  pool_pages_reg;

    // output register
    logic                        out_valid_reg;
    logic                        granted_reg;
    logic [bpa_pkg::START_W-1:0] start_page_reg;
    logic [bpa_pkg::ADDR_W-1:0]  start_address_reg;

    // sequencer hand-off
    logic                        res_valid;
    logic                        res_take;
    bpa_pkg::alloc_res_t         res;

    // bitmap RAM
    logic                                ram_we;
    logic [bpa_pkg::ROW_W-1:0]           ram_waddr;
    logic [bpa_pkg::WORD_BITS-1:0]       ram_wdata;
    logic                                ram_re;
    logic [bpa_pkg::ROW_W-1:0]           ram_raddr;
    logic [bpa_pkg::WORD_BITS-1:0]       ram_rdata;

    // word evaluator
    bpa_pkg::scan_req_t          unit_req;
    bpa_pkg::scan_rsp_t          unit_rsp;

    assign cfg_ready = 1'b1;

    // register writes; the host issues them only while idle (a rule for the host, not enforced by the block)
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_address_reg <= '0;
            pool_pages_reg   <= bpa_pkg::POOL_W'(bpa_pkg::POOL_RESET);
        end
        else if (cfg_valid)
        begin
            unique case (bpa_pkg::cfg_reg_t'(cfg_index))
                bpa_pkg::REG_BASE_ADDRESS:
                begin
                    base_address_reg <= cfg_data;
                end
                bpa_pkg::REG_POOL_PAGES:
                begin
                    pool_pages_reg <= cfg_data[bpa_pkg::POOL_W-1:0];
                end
                default:
                begin
                    base_address_reg <= base_address_reg;
                end
            endcase
        end
    end

    bpa_ram #(
        .WIDTH (bpa_pkg::WORD_BITS),
        .DEPTH (bpa_pkg::NUM_WORDS)
    ) u_bitmap_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    bpa_word_unit u_word_unit (
        .req (unit_req),
        .rsp (unit_rsp)
    );

    bpa_seq u_seq (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .page_count (page_count),
        .pool_pages (pool_pages_reg),
        .res_valid  (res_valid),
        .res_take   (res_take),
        .res        (res),
        .ram_we     (ram_we),
        .ram_waddr  (ram_waddr),
        .ram_wdata  (ram_wdata),
        .ram_re     (ram_re),
        .ram_raddr  (ram_raddr),
        .ram_rdata  (ram_rdata),
        .unit_req   (unit_req),
        .unit_rsp   (unit_rsp)
    );

    // output register frees up when empty or being drained this cycle
    assign res_take = !out_valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res_valid && res_take)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // start address wraps at 32 bits; zero on failure
    always_ff @(posedge clk)
    begin
        if (res_valid && res_take)
        begin
            granted_reg    <= res.granted;
            start_page_reg <= bpa_pkg::START_W'(res.start);
            if (res.granted)
            begin
                start_address_reg <= base_address_reg
                    + (bpa_pkg::ADDR_W'(res.start) << bpa_pkg::PAGE_SHIFT);
            end
            else
            begin
                start_address_reg <= '0;
            end
        end
    end

    assign out_valid     = out_valid_reg;
    assign granted       = granted_reg;
    assign start_page    = start_page_reg;
    assign start_address = start_address_reg;

endmodule

>>> rtl/core/bpa_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module bpa_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> rtl/core/bpa_word_unit.sv
// Word evaluator: finds the first fitting free run ending in one bitmap word.
module bpa_word_unit (
    input  bpa_pkg::scan_req_t req,
    output bpa_pkg::scan_rsp_t rsp
);

    localparam int WB = bpa_pkg::WORD_BITS;

    logic [WB-1:0]                lim_mask;
    logic [WB-1:0]                free_bits;
    logic [WB-1:0]                pre;
    logic [WB-1:0]                thresh;
    logic [WB-1:0]                int_hit;
    logic [WB-1:0]                acc;
    logic [WB-1:0]                hits;
    logic [WB-1:0]                pwin [bpa_pkg::BIT_W+1];
    logic [bpa_pkg::RUN_W-1:0]    need;
    logic [bpa_pkg::BIT_W-1:0]    low_hit;
    logic [bpa_pkg::BIT_W-1:0]    top_used;
    logic                         any_used;

    always_comb
    begin
        // pages at or beyond the pool limit count as used
        if (req.rem >= bpa_pkg::SPAN_W'(WB))
        begin
            lim_mask = '1;
        end
        else
        begin
            lim_mask = ~({WB{1'b1}} << req.rem[bpa_pkg::BIT_W-1:0]);
        end
        free_bits = ~req.used & lim_mask;

        // run continuing from below: bits 0..j all free and long enough
        need = bpa_pkg::RUN_W'(req.cnt) - req.carry;
        for (int j = 0; j < WB; j++)
        begin
            pre[j]    = &(free_bits | ({WB{1'b1}} << (j + 1)));
            thresh[j] = (bpa_pkg::RUN_W'(j + 1) >= need);
        end

        // runs wholly inside the word: windows of power-of-two length,
        // then composed to the requested length by shift and AND
        pwin[0] = free_bits;
        for (int k = 0; k < bpa_pkg::BIT_W; k++)
        begin
            pwin[k+1] = pwin[k] & (pwin[k] << (1 << k));
        end
        acc = '1;
        for (int k = 0; k <= bpa_pkg::BIT_W; k++)
        begin
            if (req.cnt[k])
            begin
                acc = acc & (pwin[k] << (req.cnt & bpa_pkg::SPAN_W'((1 << k) - 1)));
            end
        end
        int_hit = (req.cnt <= bpa_pkg::SPAN_W'(WB)) ? acc : '0;

        hits = (pre & thresh) | int_hit;

        low_hit = '0;
        for (int j = WB - 1; j >= 0; j--)
        begin
            if (hits[j])
            begin
                low_hit = bpa_pkg::BIT_W'(j);
            end
        end

        any_used = 1'b0;
        top_used = '0;
        for (int j = 0; j < WB; j++)
        begin
            if (!free_bits[j])
            begin
                top_used = bpa_pkg::BIT_W'(j);
                any_used = 1'b1;
            end
        end

        rsp.hit = |hits;
        rsp.pos = low_hit;
        if (any_used)
        begin
            rsp.carry_next = bpa_pkg::RUN_W'(bpa_pkg::BIT_W'(WB - 1) - top_used);
        end
        else
        begin
            rsp.carry_next = req.carry + bpa_pkg::RUN_W'(WB);
        end
    end

endmodule

>>> rtl/core/bpa_seq.sv
// Sequencer: word scan over the bitmap RAM, run marking and result hand-off.
module bpa_seq (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [bpa_pkg::CNT_W-1:0]           page_count,
    input  logic [bpa_pkg::POOL_W-1:0]          pool_pages,
    output logic                                res_valid,
    input  logic                                res_take,
    output bpa_pkg::alloc_res_t                 res,
    output logic                                ram_we,
    output logic [bpa_pkg::ROW_W-1:0]           ram_waddr,
    output logic [bpa_pkg::WORD_BITS-1:0]       ram_wdata,
    output logic                                ram_re,
    output logic [bpa_pkg::ROW_W-1:0]           ram_raddr,
    input  logic [bpa_pkg::WORD_BITS-1:0]       ram_rdata,
    output bpa_pkg::scan_req_t                  unit_req,
    input  bpa_pkg::scan_rsp_t                  unit_rsp
);

    localparam int WB    = bpa_pkg::WORD_BITS;
    localparam int BW    = bpa_pkg::BIT_W;
    localparam int RW    = bpa_pkg::ROW_W;
    localparam int PW    = bpa_pkg::PAGE_W;
    localparam int SW    = bpa_pkg::SPAN_W;

    bpa_pkg::seq_state_t state_reg, state_next;

    logic [SW-1:0]          cnt_reg;
    logic [SW-1:0]          lim_reg;
    logic [RW-1:0]          last_row_reg;
    logic [RW-1:0]          issue_row_reg;
    logic                   issue_done_reg;
    logic                   pend_reg;
    logic [RW-1:0]          eval_row_reg;
    logic [bpa_pkg::RUN_W-1:0] carry_reg;
    logic [PW-1:0]          start_reg;
    logic [PW-1:0]          end_reg;
    logic [WB-1:0]          last_word_reg;
    logic [RW-1:0]          row_reg;
    logic                   granted_reg;
    logic [bpa_pkg::NUM_WORDS-1:0] row_vld_reg;
    logic                   rd_vld_reg;

    logic [SW-1:0]          pool_ext;
    logic [SW-1:0]          lim_in;
    logic [SW-1:0]          cnt_in;
    logic [SW-1:0]          lim_m1;
    logic                   reject;
    logic [WB-1:0]          rd_used;
    logic [PW-1:0]          hit_end;
    logic [SW-1:0]          hit_start;
    logic [RW-1:0]          start_row;
    logic [RW-1:0]          end_row;
    logic [BW-1:0]          start_bit;
    logic [BW-1:0]          end_bit;
    logic [PW-1:0]          eval_base;

    function automatic logic [WB-1:0] bit_range(input logic [BW-1:0] lo,
                                                input logic [BW-1:0] hi);
        logic [WB-1:0] m;
        m = ({WB{1'b1}} << lo) & ({WB{1'b1}} >> (BW'(WB - 1) - hi));
        return m;
    endfunction

    // request decode
    always_comb
    begin
        pool_ext = SW'(pool_pages);
        lim_in   = (pool_ext > SW'(bpa_pkg::MAX_PAGES)) ? SW'(bpa_pkg::MAX_PAGES) : pool_ext;
        cnt_in   = SW'(page_count);
        reject   = (cnt_in == '0) || (cnt_in > lim_in);
        lim_m1   = lim_in - SW'(1);
    end

    // scan datapath
    always_comb
    begin
        rd_used   = rd_vld_reg ? ram_rdata : '0;
        eval_base = {eval_row_reg, {BW{1'b0}}};
        unit_req.used  = rd_used;
        unit_req.rem   = lim_reg - SW'(eval_base);
        unit_req.carry = carry_reg;
        unit_req.cnt   = cnt_reg;
        hit_end   = {eval_row_reg, unit_rsp.pos};
        hit_start = SW'(hit_end) + SW'(1) - cnt_reg;
        start_row = start_reg[PW-1 -: RW];
        start_bit = start_reg[BW-1:0];
        end_row   = end_reg[PW-1 -: RW];
        end_bit   = end_reg[BW-1:0];
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            bpa_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = reject ? bpa_pkg::ST_RESULT : bpa_pkg::ST_SCAN;
                end
            end
            bpa_pkg::ST_SCAN:
            begin
                if (pend_reg && unit_rsp.hit)
                begin
                    state_next = bpa_pkg::ST_MARK_RD;
                end
                else if (pend_reg && (eval_row_reg == last_row_reg))
                begin
                    state_next = bpa_pkg::ST_RESULT;
                end
            end
            bpa_pkg::ST_MARK_RD:
            begin
                state_next = bpa_pkg::ST_MARK_FIRST;
            end
            bpa_pkg::ST_MARK_FIRST:
            begin
                state_next = (start_row == end_row) ? bpa_pkg::ST_RESULT
                                                    : bpa_pkg::ST_MARK_MID;
            end
            bpa_pkg::ST_MARK_MID:
            begin
                if (row_reg == end_row)
                begin
                    state_next = bpa_pkg::ST_RESULT;
                end
            end
            bpa_pkg::ST_RESULT:
            begin
                if (res_take)
                begin
                    state_next = bpa_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = bpa_pkg::ST_IDLE;
            end
        endcase
    end

    // outputs and RAM control
    always_comb
    begin
        in_ready  = 1'b0;
        res_valid = 1'b0;
        ram_re    = 1'b0;
        ram_raddr = issue_row_reg;
        ram_we    = 1'b0;
        ram_waddr = row_reg;
        ram_wdata = '1;
        unique case (state_reg)
            bpa_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
            end
            bpa_pkg::ST_SCAN:
            begin
                ram_re = !issue_done_reg;
            end
            bpa_pkg::ST_MARK_RD:
            begin
                ram_re    = 1'b1;
                ram_raddr = start_row;
            end
            bpa_pkg::ST_MARK_FIRST:
            begin
                ram_we    = 1'b1;
                ram_waddr = start_row;
                ram_wdata = rd_used | bit_range(start_bit,
                                                (start_row == end_row) ? end_bit : '1);
            end
            bpa_pkg::ST_MARK_MID:
            begin
                // inner words were free: all ones; end row ORs in run bits
                ram_we    = 1'b1;
                ram_waddr = row_reg;
                if (row_reg == end_row)
                begin
                    ram_wdata = last_word_reg | bit_range('0, end_bit);
                end
            end
            bpa_pkg::ST_RESULT:
            begin
                res_valid = 1'b1;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
        res.granted = granted_reg;
        res.start   = granted_reg ? start_reg : '0;
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= bpa_pkg::ST_IDLE;
            issue_done_reg <= 1'b0;
            pend_reg       <= 1'b0;
            row_vld_reg    <= '0;
            rd_vld_reg     <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            pend_reg  <= ram_re && (state_reg == bpa_pkg::ST_SCAN)
                         && (state_next == bpa_pkg::ST_SCAN);
            if (state_reg == bpa_pkg::ST_IDLE)
            begin
                issue_done_reg <= 1'b0;
            end
            else if (ram_re && (state_reg == bpa_pkg::ST_SCAN)
                     && (issue_row_reg == last_row_reg))
            begin
                issue_done_reg <= 1'b1;
            end
            if (ram_we)
            begin
                row_vld_reg[ram_waddr] <= 1'b1;
            end
            if (ram_re)
            begin
                rd_vld_reg <= row_vld_reg[ram_raddr];
            end
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            bpa_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    cnt_reg       <= cnt_in;
                    lim_reg       <= lim_in;
                    last_row_reg  <= lim_m1[BW +: RW];
                    issue_row_reg <= '0;
                    carry_reg     <= '0;
                    granted_reg   <= 1'b0;
                end
            end
            bpa_pkg::ST_SCAN:
            begin
                if (ram_re)
                begin
                    issue_row_reg <= issue_row_reg + RW'(1);
                    eval_row_reg  <= issue_row_reg;
                end
                if (pend_reg)
                begin
                    carry_reg <= unit_rsp.carry_next;
                    if (unit_rsp.hit)
                    begin
                        start_reg     <= hit_start[PW-1:0];
                        end_reg       <= hit_end;
                        last_word_reg <= rd_used;
                        granted_reg   <= 1'b1;
                    end
                end
            end
            bpa_pkg::ST_MARK_FIRST:
            begin
                row_reg <= start_row + RW'(1);
            end
            bpa_pkg::ST_MARK_MID:
            begin
                row_reg <= row_reg + RW'(1);
            end
            bpa_pkg::ST_MARK_RD, bpa_pkg::ST_RESULT:
            begin
                row_reg <= row_reg;
            end
            default:
            begin
                row_reg <= row_reg;
            end
        endcase
    end

endmodule
